### hw/rtl/sef_pkg.sv
// ---------------------------------------------------------------------------
// sef_pkg: shared types and constants of the SPI EEPROM command framer
// Command codes, opcodes, header forms and the command item that the front
// end hands to the byte expander.
// ---------------------------------------------------------------------------
`default_nettype none

package sef_pkg;

  // widest address the framer can ever emit (three address bytes)
  localparam int unsigned ADDR_EXT_W = 24;

  // command queue between front end and byte expander
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  // input item modes
  localparam logic [1:0] MODE_BEGIN_READ  = 2'd0;
  localparam logic [1:0] MODE_BEGIN_WRITE = 2'd1;
  localparam logic [1:0] MODE_STEP        = 2'd2;
  localparam logic [1:0] MODE_STATUS      = 2'd3;

  // receive byte usage codes
  localparam logic [1:0] RX_IGNORE = 2'd0;
  localparam logic [1:0] RX_DATA   = 2'd1;
  localparam logic [1:0] RX_STATUS = 2'd2;

  // device opcodes
  localparam logic [7:0] OPC_READ  = 8'h03;
  localparam logic [7:0] OPC_WRITE = 8'h02;
  localparam logic [7:0] OPC_WREN  = 8'h06;
  localparam logic [7:0] OPC_RDSR  = 8'h05;
  localparam logic [7:0] OPC_A8    = 8'h08;  // ninth address bit in opcode
  localparam logic [7:0] DUMMY     = 8'h00;

  // device size thresholds
  localparam logic [17:0] MEM_NINTH_BIT = 18'd512;
  localparam logic [17:0] MEM_THREE_ADR = 18'd131072;

  // configuration register byte offsets (decoded on paddr[2])
  localparam logic [2:0] CFG_ADDR_MEMORY = 3'd0;
  localparam logic [2:0] CFG_ADDR_PAGE   = 3'd4;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_READ,
    OP_WRITE
  } op_t;

  typedef enum logic {
    FS_ACCEPT,
    FS_MODULO
  } front_state_t;

  typedef enum logic [1:0] {
    HDR_ONE,    // one address byte
    HDR_NINTH,  // one address byte, bit 8 in the opcode
    HDR_TWO,    // two address bytes
    HDR_THREE   // three address bytes
  } hdr_form_t;

  typedef enum logic [2:0] {
    CK_ERROR,
    CK_DONE,
    CK_READ_HDR,
    CK_WRITE_PAGE,
    CK_READ_BYTE,
    CK_WRITE_BYTE,
    CK_POLL
  } cmd_kind_t;

  // configuration register values
  typedef struct packed {
    logic [17:0] memory_bytes;
    logic [8:0]  page_bytes;
  } cfg_t;

  // one command for the byte expander
  typedef struct packed {
    cmd_kind_t             kind;
    logic                  flag;   // empty read / final byte / page end
    hdr_form_t             form;
    logic [ADDR_EXT_W-1:0] addr;
    logic [7:0]            data;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_start;
    logic       frame_end;
    logic [1:0] rx_use;
    logic       error;
    logic       done_res;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/sef_mod_unit.sv
// ---------------------------------------------------------------------------
// sef_mod_unit: serial remainder unit
// Restoring division one dividend bit per cycle; reports whether the
// remainder of dividend by divisor is zero.
// ---------------------------------------------------------------------------
`default_nettype none

module sef_mod_unit #(
  parameter int unsigned DIV_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [8:0]       divisor,
  output logic                  done,
  output logic                  rem_zero
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [8:0]       rem_r, rem_nxt;
  logic [8:0]       dvs_r, dvs_nxt;
  logic [9:0]       trial;

  // one restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[DIV_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 9'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[8:0];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == 9'd0);

  // a result is only flagged once the iteration has stopped
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("remainder done while still iterating");

endmodule

`default_nettype wire

### hw/rtl/sef_cmd_queue.sv
// ---------------------------------------------------------------------------
// sef_cmd_queue: command queue
// Short first-in first-out queue of commands between front end and
// byte expander.
// ---------------------------------------------------------------------------
`default_nettype none

module sef_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire sef_pkg::cmd_t wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output sef_pkg::cmd_t      rd_data,
  output logic               empty
);

  sef_pkg::cmd_t                     entry_r [sef_pkg::QUEUE_DEPTH];
  logic [sef_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sef_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [sef_pkg::QUEUE_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                              do_wr, do_rd;

  assign full    = (cnt_r == sef_pkg::QUEUE_CNT_W'(sef_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entry_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sef_front.sv
// ---------------------------------------------------------------------------
// sef_front: request front end
// Accepts items, checks them against the operation state and the device
// size, keeps cursor and byte count, and queues one command per item.
// ---------------------------------------------------------------------------
`default_nettype none

module sef_front #(
  parameter int unsigned AW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sef_pkg::cfg_t cfg,
  // item input
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    in_mode,
  input  wire logic [16:0]   in_address,
  input  wire logic [17:0]   in_length,
  input  wire logic [7:0]    in_data_byte,
  // remainder unit
  output logic               mod_start,
  output logic [AW-1:0]      mod_dividend,
  output logic [8:0]         mod_divisor,
  input  wire logic          mod_done,
  input  wire logic          mod_zero,
  // command queue
  output logic               q_push,
  output sef_pkg::cmd_t      q_data,
  input  wire logic          q_full
);

  sef_pkg::front_state_t fstate_r, fstate_nxt;
  sef_pkg::op_t          op_r, op_nxt;
  logic [AW-1:0]         cursor_r, cursor_nxt;
  logic [17:0]           remain_r, remain_nxt;
  logic                  page_open_r, page_open_nxt;
  logic                  await_r, await_nxt;
  logic [7:0]            data_r, data_nxt;

  logic                                  accept;
  logic                                  write_step;
  logic [sef_pkg::ADDR_EXT_W-1:0]        adr_ext;
  logic [AW-1:0]                         adr;
  logic                                  out_of_range;
  logic                                  page_end;
  logic [AW-1:0]                         cursor_inc;
  logic [17:0]                           remain_dec;
  sef_pkg::hdr_form_t                    form;

  assign accept     = push && !full;
  assign adr_ext    = sef_pkg::ADDR_EXT_W'(in_address);
  assign adr        = adr_ext[AW-1:0];
  assign cursor_inc = cursor_r + 1'b1;
  assign remain_dec = remain_r - 18'd1;
  assign write_step = (in_mode == sef_pkg::MODE_STEP) && (op_r == sef_pkg::OP_WRITE)
                      && page_open_r;
  assign out_of_range = (25'(adr) + 25'(in_length)) > 25'(cfg.memory_bytes);
  assign page_end     = (remain_r == 18'd0) || mod_zero;

  // header form from the device size
  always_comb begin
    if (cfg.memory_bytes < sef_pkg::MEM_NINTH_BIT) begin
      form = sef_pkg::HDR_ONE;
    end else if (cfg.memory_bytes == sef_pkg::MEM_NINTH_BIT) begin
      form = sef_pkg::HDR_NINTH;
    end else if (cfg.memory_bytes < sef_pkg::MEM_THREE_ADR) begin
      form = sef_pkg::HDR_TWO;
    end else begin
      form = sef_pkg::HDR_THREE;
    end
  end

  // next state
  always_comb begin
    fstate_nxt = fstate_r;
    unique case (fstate_r)
      sef_pkg::FS_ACCEPT: begin
        if (accept && write_step) begin
          fstate_nxt = sef_pkg::FS_MODULO;
        end
      end
      sef_pkg::FS_MODULO: begin
        if (mod_done) begin
          fstate_nxt = sef_pkg::FS_ACCEPT;
        end
      end
      default: fstate_nxt = sef_pkg::FS_ACCEPT;
    endcase
  end

  // state outputs
  always_comb begin
    unique case (fstate_r)
      sef_pkg::FS_ACCEPT: full = q_full;
      sef_pkg::FS_MODULO: full = 1'b1;
      default:            full = 1'b1;
    endcase
  end

  // classification and operation state update
  always_comb begin
    op_nxt        = op_r;
    cursor_nxt    = cursor_r;
    remain_nxt    = remain_r;
    page_open_nxt = page_open_r;
    await_nxt     = await_r;
    data_nxt      = data_r;
    q_push        = 1'b0;
    q_data.kind   = sef_pkg::CK_ERROR;
    q_data.flag   = 1'b0;
    q_data.form   = form;
    q_data.addr   = sef_pkg::ADDR_EXT_W'(cursor_r);
    q_data.data   = data_r;
    mod_start     = 1'b0;

    if (fstate_r == sef_pkg::FS_MODULO) begin
      // data byte of a write, once the page boundary test is known
      if (mod_done) begin
        q_push      = 1'b1;
        q_data.kind = sef_pkg::CK_WRITE_BYTE;
        q_data.flag = page_end;
        if (page_end) begin
          page_open_nxt = 1'b0;
          await_nxt     = 1'b1;
        end
      end
    end else if (accept) begin
      q_push = 1'b1;
      case (in_mode)
        sef_pkg::MODE_BEGIN_READ: begin
          if (op_r == sef_pkg::OP_IDLE && !out_of_range) begin
            q_data.kind = sef_pkg::CK_READ_HDR;
            q_data.addr = sef_pkg::ADDR_EXT_W'(adr);
            q_data.flag = (in_length == 18'd0);
            if (in_length != 18'd0) begin
              op_nxt     = sef_pkg::OP_READ;
              cursor_nxt = adr;
              remain_nxt = in_length;
            end
          end
        end
        sef_pkg::MODE_BEGIN_WRITE: begin
          if (op_r == sef_pkg::OP_IDLE && !out_of_range) begin
            if (in_length == 18'd0) begin
              q_data.kind = sef_pkg::CK_DONE;
            end else begin
              q_data.kind   = sef_pkg::CK_WRITE_PAGE;
              q_data.addr   = sef_pkg::ADDR_EXT_W'(adr);
              op_nxt        = sef_pkg::OP_WRITE;
              cursor_nxt    = adr;
              remain_nxt    = in_length;
              await_nxt     = 1'b0;
              page_open_nxt = 1'b1;
            end
          end
        end
        sef_pkg::MODE_STEP: begin
          if (op_r == sef_pkg::OP_READ) begin
            q_data.kind = sef_pkg::CK_READ_BYTE;
            q_data.flag = (remain_dec == 18'd0);
            remain_nxt  = remain_dec;
            cursor_nxt  = cursor_inc;
            if (remain_dec == 18'd0) begin
              op_nxt = sef_pkg::OP_IDLE;
            end
          end else if (write_step) begin
            // command goes out once the remainder is known
            q_push     = 1'b0;
            remain_nxt = remain_dec;
            cursor_nxt = cursor_inc;
            data_nxt   = in_data_byte;
            mod_start  = 1'b1;
          end
        end
        default: begin
          // status byte received
          if (op_r == sef_pkg::OP_WRITE && await_r) begin
            if (in_data_byte[0]) begin
              q_data.kind = sef_pkg::CK_POLL;
            end else begin
              await_nxt = 1'b0;
              if (remain_r == 18'd0) begin
                q_data.kind = sef_pkg::CK_DONE;
                op_nxt      = sef_pkg::OP_IDLE;
              end else begin
                q_data.kind   = sef_pkg::CK_WRITE_PAGE;
                page_open_nxt = 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  assign mod_dividend = cursor_inc;
  assign mod_divisor  = (cfg.page_bytes == 9'd0) ? 9'd1 : cfg.page_bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r    <= sef_pkg::FS_ACCEPT;
      op_r        <= sef_pkg::OP_IDLE;
      cursor_r    <= '0;
      remain_r    <= '0;
      page_open_r <= 1'b0;
      await_r     <= 1'b0;
    end else begin
      fstate_r    <= fstate_nxt;
      op_r        <= op_nxt;
      cursor_r    <= cursor_nxt;
      remain_r    <= remain_nxt;
      page_open_r <= page_open_nxt;
      await_r     <= await_nxt;
    end
    data_r <= data_nxt;
  end

  // a page frame and a status poll never overlap
  a_open_vs_poll: assert property (@(posedge clk) disable iff (!rst_n)
    !(page_open_r && await_r))
    else $error("page frame open while a status poll is pending");

  // no write bookkeeping left behind in idle
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (op_r == sef_pkg::OP_IDLE) |-> (!page_open_r && !await_r))
    else $error("idle with write state still set");

  // the slot taken at acceptance is still free when the data byte is queued
  a_mod_room: assert property (@(posedge clk) disable iff (!rst_n)
    (fstate_r == sef_pkg::FS_MODULO) |-> !q_full)
    else $error("command queue full during remainder wait");

endmodule

`default_nettype wire

### hw/rtl/sef_back.sv
// ---------------------------------------------------------------------------
// sef_back: byte expander
// Turns each queued command into its sequence of SPI bytes and marks, one
// result per cycle into an output register, while that register is free or popped.
// ---------------------------------------------------------------------------
`default_nettype none

module sef_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // command queue
  input  wire sef_pkg::cmd_t q_data,
  input  wire logic          q_empty,
  output logic               q_pop,
  // result register
  output sef_pkg::res_t      res,
  output logic               res_valid,
  input  wire logic          res_pop
);

  logic [2:0]    idx_r, idx_nxt;
  logic          valid_r, valid_nxt;
  sef_pkg::res_t res_r, res_nxt;

  sef_pkg::res_t cur;
  logic [2:0]    count;
  logic [2:0]    hlen;
  logic [2:0]    hk;        // header byte position
  logic [2:0]    hj;        // address byte, counted from the low end
  logic [7:0]    hopc;
  logic [7:0]    hbyte;
  logic          produce;
  logic          is_last;

  // header length by form
  always_comb begin
    case (q_data.form)
      sef_pkg::HDR_TWO:   hlen = 3'd3;
      sef_pkg::HDR_THREE: hlen = 3'd4;
      default:            hlen = 3'd2;
    endcase
  end

  // opcode or address byte at header position hk
  always_comb begin
    hk = (q_data.kind == sef_pkg::CK_WRITE_PAGE) ? idx_r - 3'd1 : idx_r;
    hj = hlen - 3'd1 - hk;
    hopc = (q_data.kind == sef_pkg::CK_WRITE_PAGE) ? sef_pkg::OPC_WRITE
                                                    : sef_pkg::OPC_READ;
    if (q_data.form == sef_pkg::HDR_NINTH && (|q_data.addr[23:8])) begin
      hopc = hopc | sef_pkg::OPC_A8;
    end
    if (hk == 3'd0) begin
      hbyte = hopc;
    end else begin
      case (hj)
        3'd1:    hbyte = q_data.addr[15:8];
        3'd2:    hbyte = q_data.addr[23:16];
        default: hbyte = q_data.addr[7:0];
      endcase
    end
  end

  // result at the current position of the current command
  always_comb begin
    cur   = '0;
    count = 3'd1;
    unique case (q_data.kind)
      sef_pkg::CK_ERROR: begin
        cur.error = 1'b1;
      end
      sef_pkg::CK_DONE: begin
        cur.done_res = 1'b1;
      end
      sef_pkg::CK_READ_BYTE: begin
        cur.tx_byte   = sef_pkg::DUMMY;
        cur.rx_use    = sef_pkg::RX_DATA;
        cur.frame_end = q_data.flag;
        cur.done_res  = q_data.flag;
      end
      sef_pkg::CK_POLL: begin
        count = 3'd2;
        if (idx_r == 3'd0) begin
          cur.tx_byte     = sef_pkg::OPC_RDSR;
          cur.frame_start = 1'b1;
        end else begin
          cur.tx_byte   = sef_pkg::DUMMY;
          cur.frame_end = 1'b1;
          cur.rx_use    = sef_pkg::RX_STATUS;
        end
      end
      sef_pkg::CK_WRITE_BYTE: begin
        count = q_data.flag ? 3'd3 : 3'd1;
        case (idx_r)
          3'd0: begin
            cur.tx_byte   = q_data.data;
            cur.frame_end = q_data.flag;
          end
          3'd1: begin
            cur.tx_byte     = sef_pkg::OPC_RDSR;
            cur.frame_start = 1'b1;
          end
          default: begin
            cur.tx_byte   = sef_pkg::DUMMY;
            cur.frame_end = 1'b1;
            cur.rx_use    = sef_pkg::RX_STATUS;
          end
        endcase
      end
      sef_pkg::CK_READ_HDR: begin
        count           = hlen;
        cur.tx_byte     = hbyte;
        cur.frame_start = (idx_r == 3'd0);
        if (idx_r == hlen - 3'd1 && q_data.flag) begin
          cur.frame_end = 1'b1;
          cur.done_res  = 1'b1;
        end
      end
      sef_pkg::CK_WRITE_PAGE: begin
        count = hlen + 3'd1;
        if (idx_r == 3'd0) begin
          cur.tx_byte     = sef_pkg::OPC_WREN;
          cur.frame_start = 1'b1;
          cur.frame_end   = 1'b1;
        end else begin
          cur.tx_byte     = hbyte;
          cur.frame_start = (idx_r == 3'd1);
        end
      end
      default: begin
        cur.error = 1'b1;
      end
    endcase
    is_last  = (idx_r == count - 3'd1);
    cur.last = is_last;
  end

  // load the output register whenever it is free or being emptied
  always_comb begin
    produce   = !q_empty && (!valid_r || res_pop);
    q_pop     = produce && is_last;
    valid_nxt = valid_r;
    res_nxt   = res_r;
    idx_nxt   = idx_r;
    if (res_pop && valid_r) begin
      valid_nxt = 1'b0;
    end
    if (produce) begin
      valid_nxt = 1'b1;
      res_nxt   = cur;
      idx_nxt   = is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign res       = res_r;
  assign res_valid = valid_r;

  // position within a command stays inside its byte count
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> (idx_r < count))
    else $error("expander position past end of command");

  // an error result carries no bus byte and ends its item
  a_error_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && res_r.error) |-> (res_r.tx_byte == 8'd0 && res_r.last
                                  && !res_r.frame_start && !res_r.frame_end))
    else $error("error result carries bus data");

endmodule

`default_nettype wire

### hw/rtl/spi_eeprom_command_framer.sv
// ---------------------------------------------------------------------------
// spi_eeprom_command_framer: 25xx serial EEPROM command framer
// Turns read/write requests into SPI transmit bytes with chip select marks.
// ---------------------------------------------------------------------------
// Each accepted item yields one to five result items, delivered one per
// clock cycle from the byte expander while the result register is free or
// popped; the result rate sets the sustained throughput. Items are taken one
// per cycle into a four-entry command queue while it has room, except a
// write data step, which holds the input side while the serial remainder
// unit tests the page boundary. Registers memory_bytes (byte offset 0) and
// page_bytes (byte offset 4) are to be written by the user over the APB port
// only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module spi_eeprom_command_framer #(
  parameter int unsigned ADDR_BITS = 17
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // item input
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_mode,
  input  wire logic [16:0] in_address,
  input  wire logic [17:0] in_length,
  input  wire logic [7:0]  in_data_byte,
  // result output
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_tx_byte,
  output logic             out_frame_start,
  output logic             out_frame_end,
  output logic [1:0]       out_rx_use,
  output logic             out_error,
  output logic             out_done_res,
  output logic             out_last,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [17:0] mem_bytes_r, mem_bytes_nxt;
  logic [8:0]  page_bytes_r, page_bytes_nxt;
  logic        cfg_wr;

  sef_pkg::cfg_t cfg;

  logic                 mod_start;
  logic [ADDR_BITS-1:0] mod_dividend;
  logic [8:0]           mod_divisor;
  logic                 mod_done;
  logic                 mod_zero;

  logic          q_push, q_full, q_pop, q_empty;
  sef_pkg::cmd_t q_wr_data, q_rd_data;

  sef_pkg::res_t res;
  logic          res_valid;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    mem_bytes_nxt  = mem_bytes_r;
    page_bytes_nxt = page_bytes_r;
    if (cfg_wr) begin
      if (paddr[2] == sef_pkg::CFG_ADDR_PAGE[2]) begin
        page_bytes_nxt = pwdata[8:0];
      end else begin
        mem_bytes_nxt = pwdata[17:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_bytes_r  <= 18'd128;
      page_bytes_r <= 9'd16;
    end else begin
      mem_bytes_r  <= mem_bytes_nxt;
      page_bytes_r <= page_bytes_nxt;
    end
  end

  // register readback
  always_comb begin
    if (paddr[2] == sef_pkg::CFG_ADDR_PAGE[2]) begin
      prdata = 32'(page_bytes_r);
    end else begin
      prdata = 32'(mem_bytes_r);
    end
  end

  assign cfg.memory_bytes = mem_bytes_r;
  assign cfg.page_bytes   = page_bytes_r;

  sef_front #(
    .AW (ADDR_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .in_mode      (in_mode),
    .in_address   (in_address),
    .in_length    (in_length),
    .in_data_byte (in_data_byte),
    .mod_start    (mod_start),
    .mod_dividend (mod_dividend),
    .mod_divisor  (mod_divisor),
    .mod_done     (mod_done),
    .mod_zero     (mod_zero),
    .q_push       (q_push),
    .q_data       (q_wr_data),
    .q_full       (q_full)
  );

  sef_mod_unit #(
    .DIV_W (ADDR_BITS)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem_zero (mod_zero)
  );

  sef_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  sef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_rd_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  // result ports
  assign empty           = !res_valid;
  assign out_tx_byte     = res.tx_byte;
  assign out_frame_start = res.frame_start;
  assign out_frame_end   = res.frame_end;
  assign out_rx_use      = res.rx_use;
  assign out_error       = res.error;
  assign out_done_res    = res.done_res;
  assign out_last        = res.last;

endmodule

`default_nettype wire

### dv/spi_eeprom_command_framer_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// spi_eeprom_command_framer_checker: bus byte predictor and result scoreboard
// Watches the item, result and register ports of the framer, works out the
// SPI bytes each accepted request item must produce and compares every
// popped result against the oldest outstanding prediction.
// ---------------------------------------------------------------------------

module spi_eeprom_command_framer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_mode,
  input  logic [16:0] in_address,
  input  logic [17:0] in_length,
  input  logic [7:0]  in_data_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_tx_byte,
  input  logic        out_frame_start,
  input  logic        out_frame_end,
  input  logic [1:0]  out_rx_use,
  input  logic        out_error,
  input  logic        out_done_res,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count,
  output int unsigned results_checked,
  output int unsigned results_due
);

  // shadow registers and transfer state
  logic [17:0]    dev_bytes;
  logic [8:0]     page_size;
  sef_pkg::op_t   busy_op;
  logic [16:0]    next_addr;
  logic [17:0]    bytes_left;
  logic           in_page;
  logic           poll_due;

  // bus bytes still owed by the framer, oldest first
  sef_pkg::res_t  bus_due[$];

  task automatic emit(input logic [7:0] tx, input logic fs, input logic fe,
                      input logic [1:0] rx, input logic err, input logic fin);
    sef_pkg::res_t r;
    r.tx_byte     = tx;
    r.frame_start = fs;
    r.frame_end   = fe;
    r.rx_use      = rx;
    r.error       = err;
    r.done_res    = fin;
    r.last        = 1'b0;
    bus_due.push_back(r);
  endtask

  // opcode plus address bytes, form set by the device size
  task automatic emit_header(input logic [7:0] opcode, input logic [16:0] adr);
    if (dev_bytes < sef_pkg::MEM_NINTH_BIT) begin
      emit(opcode, 1'b1, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
      emit(adr[7:0], 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
    end else if (dev_bytes == sef_pkg::MEM_NINTH_BIT) begin
      emit((adr > 17'd255) ? (opcode | sef_pkg::OPC_A8) : opcode, 1'b1, 1'b0,
           sef_pkg::RX_IGNORE, 1'b0, 1'b0);
      emit(adr[7:0], 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
    end else if (dev_bytes < sef_pkg::MEM_THREE_ADR) begin
      emit(opcode, 1'b1, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
      emit(adr[15:8], 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
      emit(adr[7:0], 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
    end else begin
      emit(opcode, 1'b1, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
      emit({7'd0, adr[16]}, 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
      emit(adr[15:8], 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
      emit(adr[7:0], 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
    end
  endtask

  // write enable frame, then the page write header
  task automatic open_page();
    emit(sef_pkg::OPC_WREN, 1'b1, 1'b1, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
    emit_header(sef_pkg::OPC_WRITE, next_addr);
    in_page = 1'b1;
  endtask

  task automatic start_poll();
    emit(sef_pkg::OPC_RDSR, 1'b1, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
    emit(sef_pkg::DUMMY, 1'b0, 1'b1, sef_pkg::RX_STATUS, 1'b0, 1'b0);
    poll_due = 1'b1;
  endtask

  // expected bus bytes for one accepted request item
  task automatic frame_request(input logic [1:0] mode, input logic [16:0] adr,
                               input logic [17:0] len, input logic [7:0] dat);
    int unsigned   span;
    int unsigned   page;
    sef_pkg::res_t tail;
    span = 32'(adr);
    span = span + 32'(len);
    page = (page_size == 9'd0) ? 1 : 32'(page_size);
    case (mode) inside
      sef_pkg::MODE_BEGIN_READ, sef_pkg::MODE_BEGIN_WRITE: begin
        if (busy_op != sef_pkg::OP_IDLE || span > dev_bytes) begin
          emit(sef_pkg::DUMMY, 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b1, 1'b0);
        end else if (mode == sef_pkg::MODE_BEGIN_READ) begin
          emit_header(sef_pkg::OPC_READ, adr);
          if (len == 18'd0) begin
            // empty read closes the frame on the last address byte
            tail = bus_due.pop_back();
            tail.frame_end = 1'b1;
            tail.done_res  = 1'b1;
            bus_due.push_back(tail);
          end else begin
            busy_op    = sef_pkg::OP_READ;
            next_addr  = adr;
            bytes_left = len;
          end
        end else if (len == 18'd0) begin
          emit(sef_pkg::DUMMY, 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b1);
        end else begin
          busy_op    = sef_pkg::OP_WRITE;
          next_addr  = adr;
          bytes_left = len;
          poll_due   = 1'b0;
          open_page();
        end
      end
      sef_pkg::MODE_STEP: begin
        if (busy_op == sef_pkg::OP_READ) begin
          bytes_left = bytes_left - 1'b1;
          next_addr  = next_addr + 1'b1;
          if (bytes_left == 18'd0) begin
            busy_op = sef_pkg::OP_IDLE;
            emit(sef_pkg::DUMMY, 1'b0, 1'b1, sef_pkg::RX_DATA, 1'b0, 1'b1);
          end else begin
            emit(sef_pkg::DUMMY, 1'b0, 1'b0, sef_pkg::RX_DATA, 1'b0, 1'b0);
          end
        end else if (busy_op != sef_pkg::OP_WRITE || !in_page) begin
          emit(sef_pkg::DUMMY, 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b1, 1'b0);
        end else begin
          bytes_left = bytes_left - 1'b1;
          next_addr  = next_addr + 1'b1;
          // page closes on the final byte or at a page boundary
          if (bytes_left == 18'd0 || (next_addr % page) == 0) begin
            emit(dat, 1'b0, 1'b1, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
            in_page = 1'b0;
            start_poll();
          end else begin
            emit(dat, 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b0);
          end
        end
      end
      default: begin
        if (busy_op != sef_pkg::OP_WRITE || !poll_due) begin
          emit(sef_pkg::DUMMY, 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b1, 1'b0);
        end else if (dat[0]) begin
          start_poll();
        end else begin
          poll_due = 1'b0;
          if (bytes_left == 18'd0) begin
            busy_op = sef_pkg::OP_IDLE;
            emit(sef_pkg::DUMMY, 1'b0, 1'b0, sef_pkg::RX_IGNORE, 1'b0, 1'b1);
          end else begin
            open_page();
          end
        end
      end
    endcase
    tail = bus_due.pop_back();
    tail.last = 1'b1;
    bus_due.push_back(tail);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: result %0d %s expected %0h actual %0h", $time,
               results_checked, name, want_v, got_v);
      fail_count++;
    end
  endtask

  task automatic check_result();
    sef_pkg::res_t want;
    results_checked++;
    if (bus_due.size() == 0) begin
      $display("%0t: result %0d with nothing expected, actual tx %0h fs %0b fe %0b",
               $time, results_checked, out_tx_byte, out_frame_start, out_frame_end);
      $display("    rx %0d err %0b done %0b last %0b",
               out_rx_use, out_error, out_done_res, out_last);
      fail_count++;
    end else begin
      want = bus_due.pop_front();
      compare_field("tx_byte", want.tx_byte, out_tx_byte);
      compare_field("frame_start", want.frame_start, out_frame_start);
      compare_field("frame_end", want.frame_end, out_frame_end);
      compare_field("rx_use", want.rx_use, out_rx_use);
      compare_field("error", want.error, out_error);
      compare_field("done_res", want.done_res, out_done_res);
      compare_field("last", want.last, out_last);
    end
  endtask

  // sample all handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      dev_bytes       = 18'd128;
      page_size       = 9'd16;
      busy_op         = sef_pkg::OP_IDLE;
      next_addr       = '0;
      bytes_left      = '0;
      in_page         = 1'b0;
      poll_due        = 1'b0;
      bus_due.delete();
      fail_count      = 0;
      results_checked = 0;
      results_due     = 0;
    end else begin
      if (pop && !empty) check_result();
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          sef_pkg::CFG_ADDR_MEMORY: dev_bytes = pwdata[17:0];
          sef_pkg::CFG_ADDR_PAGE:   page_size = pwdata[8:0];
          default: ;
        endcase
      end
      if (push && !full) frame_request(in_mode, in_address, in_length, in_data_byte);
      results_due = bus_due.size();
    end
  end

endmodule

### dv/tb_spi_eeprom_command_framer.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_spi_eeprom_command_framer: stimulus and verdict for the command framer
// Drives directed corner requests, then phases of random read and write
// transfers with stray requests, across device and page sizes and under
// varied sender gaps and receiver stalls; the checker scores the results.
// ---------------------------------------------------------------------------

module tb_spi_eeprom_command_framer;

  localparam int unsigned RANDOM_ITEMS = 280;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
  } flow_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        push            = 1'b0;
  logic        full;
  logic [1:0]  in_mode         = sef_pkg::MODE_BEGIN_READ;
  logic [16:0] in_address      = '0;
  logic [17:0] in_length       = '0;
  logic [7:0]  in_data_byte    = '0;
  logic        empty;
  logic        pop             = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_frame_start;
  logic        out_frame_end;
  logic [1:0]  out_rx_use;
  logic        out_error;
  logic        out_done_res;
  logic        out_last;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned results_checked;
  int unsigned results_due;

  // stimulus knobs and shadows
  int unsigned items_sent  = 0;
  int unsigned send_idle   = 0;
  int unsigned stall_pct   = 0;
  int unsigned cfg_mem     = 128;
  int unsigned cfg_page    = 16;
  logic        hold_req    = 1'b0;
  logic        hold_done   = 1'b0;
  int unsigned hold_left   = 0;

  spi_eeprom_command_framer #(
    .ADDR_BITS(17)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_mode        (in_mode),
    .in_address     (in_address),
    .in_length      (in_length),
    .in_data_byte   (in_data_byte),
    .empty          (empty),
    .pop            (pop),
    .out_tx_byte    (out_tx_byte),
    .out_frame_start(out_frame_start),
    .out_frame_end  (out_frame_end),
    .out_rx_use     (out_rx_use),
    .out_error      (out_error),
    .out_done_res   (out_done_res),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  spi_eeprom_command_framer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_mode        (in_mode),
    .in_address     (in_address),
    .in_length      (in_length),
    .in_data_byte   (in_data_byte),
    .empty          (empty),
    .pop            (pop),
    .out_tx_byte    (out_tx_byte),
    .out_frame_start(out_frame_start),
    .out_frame_end  (out_frame_end),
    .out_rx_use     (out_rx_use),
    .out_error      (out_error),
    .out_done_res   (out_done_res),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .results_checked(results_checked),
    .results_due    (results_due)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case the framer hangs
  initial begin
    #3_000_000;
    $display("spi_eeprom_command_framer test failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one item and wait until it is taken; push stays high afterwards
  task automatic send_item(input logic [1:0] mode, input logic [16:0] adr,
                           input logic [17:0] len, input logic [7:0] dat);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    push         <= 1'b1;
    in_mode      <= mode;
    in_address   <= adr;
    in_length    <= len;
    in_data_byte <= dat;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // item with random address, length and data fields
  task automatic send_stray(input logic [1:0] mode);
    send_item(mode, 17'($urandom_range(131071)), 18'($urandom_range(262143)),
              8'($urandom_range(255)));
  endtask

  function automatic logic [1:0] stray_mode(input logic [1:0] alt);
    if ($urandom_range(2) == 0) return alt;
    return $urandom_range(1) ? sef_pkg::MODE_BEGIN_WRITE : sef_pkg::MODE_BEGIN_READ;
  endfunction

  // stop offering and wait until every expected result has come out
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
  endtask

  // back-to-back APB writes of both registers
  task automatic configure(input int unsigned mem, input int unsigned page);
    int unsigned i;
    for (i = 0; i < 2; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= (i == 0) ? sef_pkg::CFG_ADDR_MEMORY : sef_pkg::CFG_ADDR_PAGE;
      pwdata  <= (i == 0) ? mem : page;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_mem  = mem;
    cfg_page = page;
  endtask

  // legal start address and length, often just short of a page boundary
  task automatic pick_span(output logic [16:0] adr, output logic [17:0] len);
    int unsigned n, r, top_adr, base, aligned, pg;
    r = $urandom_range(9);
    n = (r == 0) ? 0 : (r < 8) ? $urandom_range(8, 1) : $urandom_range(30, 9);
    top_adr = cfg_mem - n;
    if (top_adr > 131071) top_adr = 131071;
    base = $urandom_range(top_adr);
    pg = (cfg_page == 0) ? 1 : cfg_page;
    if ($urandom_range(2) == 0) begin
      aligned = (base / pg) * pg;
      if (aligned >= 3) base = aligned - $urandom_range(3, 1);
    end
    if ($urandom_range(15) == 0) base = top_adr;
    adr = base[16:0];
    len = n[17:0];
  endtask

  task automatic run_read();
    logic [16:0] adr;
    logic [17:0] len;
    int unsigned i;
    pick_span(adr, len);
    send_item(sef_pkg::MODE_BEGIN_READ, adr, len, 8'($urandom_range(255)));
    for (i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_stray(stray_mode(sef_pkg::MODE_STATUS));
      send_stray(sef_pkg::MODE_STEP);
    end
  endtask

  task automatic run_write();
    logic [16:0] adr, cur;
    logic [17:0] len, left;
    logic [7:0]  status;
    int unsigned pg;
    pick_span(adr, len);
    pg = (cfg_page == 0) ? 1 : cfg_page;
    send_item(sef_pkg::MODE_BEGIN_WRITE, adr, len, 8'($urandom_range(255)));
    cur  = adr;
    left = len;
    while (left != 0) begin
      if ($urandom_range(9) == 0) send_stray(stray_mode(sef_pkg::MODE_STATUS));
      send_stray(sef_pkg::MODE_STEP);
      cur  = cur + 1'b1;
      left = left - 1'b1;
      // page closed: poll until the device reports ready
      if (left == 0 || (cur % pg) == 0) begin
        if ($urandom_range(9) == 0) send_stray(stray_mode(sef_pkg::MODE_STEP));
        repeat ($urandom_range(2)) begin
          status = 8'($urandom_range(255));
          status[0] = 1'b1;
          send_item(sef_pkg::MODE_STATUS, 17'($urandom_range(131071)),
                    18'($urandom_range(262143)), status);
        end
        status = 8'($urandom_range(255));
        status[0] = 1'b0;
        send_item(sef_pkg::MODE_STATUS, 17'($urandom_range(131071)),
                  18'($urandom_range(262143)), status);
      end
    end
  endtask

  // requests refused while idle
  task automatic run_refusals();
    logic [16:0] adr;
    int unsigned lo;
    repeat ($urandom_range(2, 1)) begin
      case ($urandom_range(2))
        0: begin
          adr = 17'($urandom_range(131071));
          lo  = (adr > cfg_mem) ? 0 : cfg_mem - adr + 1;
          send_item($urandom_range(1) ? sef_pkg::MODE_BEGIN_WRITE
                                      : sef_pkg::MODE_BEGIN_READ, adr,
                    18'($urandom_range(262143, lo)), 8'($urandom_range(255)));
        end
        1: send_stray(sef_pkg::MODE_STEP);
        default: send_stray(sef_pkg::MODE_STATUS);
      endcase
    end
  endtask

  initial begin
    int unsigned p, target, directed_items, mem, page, pick;
    flow_t flow;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners at reset sizes (128-byte device, 16-byte page)
    send_item(sef_pkg::MODE_STATUS, 17'd0, 18'd0, 8'h00);       // status with no poll
    send_item(sef_pkg::MODE_STEP, 17'd0, 18'd0, 8'h00);         // step while idle
    send_item(sef_pkg::MODE_BEGIN_READ, 17'd127, 18'd2, 8'h00); // past end of device
    send_item(sef_pkg::MODE_BEGIN_READ, 17'd0, 18'd0, 8'h00);   // empty read
    send_item(sef_pkg::MODE_BEGIN_WRITE, 17'd5, 18'd0, 8'h00);  // empty write
    send_item(sef_pkg::MODE_BEGIN_READ, 17'd127, 18'd1, 8'h00); // last byte of device
    send_item(sef_pkg::MODE_STEP, 17'd0, 18'd0, 8'hFF);
    send_item(sef_pkg::MODE_BEGIN_WRITE, 17'd14, 18'd3, 8'h00); // crosses a page
    send_item(sef_pkg::MODE_STEP, 17'd0, 18'd0, 8'hFF);
    send_item(sef_pkg::MODE_STEP, 17'd0, 18'd0, 8'h00);         // page end, poll
    send_item(sef_pkg::MODE_STEP, 17'd0, 18'd0, 8'h5A);         // step during poll
    send_item(sef_pkg::MODE_BEGIN_READ, 17'd0, 18'd1, 8'h00);   // begin while busy
    send_item(sef_pkg::MODE_STATUS, 17'd0, 18'd0, 8'h01);       // still busy
    send_item(sef_pkg::MODE_STATUS, 17'd0, 18'd0, 8'hFE);       // ready, next page
    send_item(sef_pkg::MODE_STEP, 17'd0, 18'd0, 8'hA5);
    send_item(sef_pkg::MODE_STATUS, 17'd0, 18'd0, 8'h00);       // write complete

    // register change in the middle of a write
    send_item(sef_pkg::MODE_BEGIN_WRITE, 17'd0, 18'd4, 8'h00);
    drain();
    configure(512, 2);
    send_item(sef_pkg::MODE_STEP, 17'd0, 18'd0, 8'h11);
    send_item(sef_pkg::MODE_STEP, 17'd0, 18'd0, 8'h22);
    send_item(sef_pkg::MODE_STATUS, 17'd0, 18'd0, 8'h00);
    send_item(sef_pkg::MODE_STEP, 17'd0, 18'd0, 8'h33);
    send_item(sef_pkg::MODE_STEP, 17'd0, 18'd0, 8'h44);
    send_item(sef_pkg::MODE_STATUS, 17'd0, 18'd0, 8'h00);
    directed_items = items_sent;

    // random phases over device sizes, page sizes and flow patterns
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin mem = 131072; page = 0;   flow = FLOW_FREE;        end
        1: begin mem = 512;    page = 16;  flow = FLOW_SEND_GAPS;   end
        2: begin mem = 256;    page = 1;   flow = FLOW_RECV_STALLS; end
        3: begin mem = 65536;  page = 256; flow = FLOW_BOTH;        end
        4: begin mem = 1000;   page = 7;   flow = FLOW_FREE;        end
        5: begin mem = 128;    page = 32;  flow = FLOW_SEND_GAPS;   end
        6: begin mem = 131072; page = 64;  flow = FLOW_RECV_STALLS; end
        default: begin mem = 513; page = 3; flow = FLOW_BOTH;       end
      endcase
      drain();
      configure(mem, page);
      case (flow)
        FLOW_FREE:        begin send_idle = 0;  stall_pct <= 0;  end
        FLOW_SEND_GAPS:   begin send_idle = 57; stall_pct <= 0;  end
        FLOW_RECV_STALLS: begin send_idle = 0;  stall_pct <= 57; end
        default:          begin send_idle = 8;  stall_pct <= 8;  end
      endcase
      // long output hold-off so the framer backs up into its input
      if (p == 0) hold_req <= 1'b1;
      target = directed_items + (p + 1) * RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 40) run_write();
        else if (pick < 75) run_read();
        else run_refusals();
      end
    end
    drain();

    $display("Covered %0d request items (%0d directed) across %0d register settings,",
             items_sent, directed_items, PHASES + 2);
    $display("with sender gaps, receiver stalls and one long hold-off; %0d results compared.",
             results_checked);
    if (fail_count == 0) begin
      $display("spi_eeprom_command_framer test passed");
    end else begin
      $display("spi_eeprom_command_framer test failed");
    end
    $finish;
  end

endmodule

### spi_eeprom_command_framer.f
hw/rtl/sef_pkg.sv
hw/rtl/sef_mod_unit.sv
hw/rtl/sef_cmd_queue.sv
hw/rtl/sef_front.sv
hw/rtl/sef_back.sv
hw/rtl/spi_eeprom_command_framer.sv
dv/spi_eeprom_command_framer_checker.sv
dv/tb_spi_eeprom_command_framer.sv
